// ----- src/refcounted_name_tag_allocator_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef REFCOUNTED_NAME_TAG_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_NAME_TAG_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RNTA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define RNTA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("reset assertion failed");
`else
`define RNTA_ASSERT(lbl, prop)
`define RNTA_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- src/rnta_pkg.sv -----
`timescale 1ns / 1ps

package rnta_pkg;

    localparam int MAX_TAGS   = 64;
    localparam int NAME_BYTES = 8;
    localparam int IDX_W      = $clog2(MAX_TAGS);
    localparam int TAG_W      = 7;
    localparam int NAME_W     = 64;
    localparam int REFS_W     = 16;
    localparam int STAT_W     = 3;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 16;

    localparam logic [STAT_W-1:0] ST_MATCHED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_HELD      = 3'd3;
    localparam logic [STAT_W-1:0] ST_FREED     = 3'd4;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd5;

    typedef struct packed {
        logic [REFS_W-1:0] refs;
        logic [NAME_W-1:0] name;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // bounded copy: keep bytes up to first zero, at most NAME_BYTES-1 of them
    function automatic logic [NAME_W-1:0] f_normalize(input logic [NAME_W-1:0] key);
        logic [NAME_W-1:0] kept;
        logic              stop;
        kept = '0;
        stop = 1'b0;
        for (int b = 0; b < NAME_W / 8; b++) begin
            if (b + 1 >= NAME_BYTES) begin
                stop = 1'b1;
            end else if (key[8*b +: 8] == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                kept[8*b +: 8] = key[8*b +: 8];
            end
        end
        return kept;
    endfunction

endpackage

// ----- src/rnta_ram.sv -----
`timescale 1ns / 1ps

module rnta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/refcounted_name_tag_allocator.sv -----
`timescale 1ns / 1ps
`include "refcounted_name_tag_allocator_defines.svh"

// Name-to-tag allocator with reference counts. Each input transfer is an
// acquire (tuser 0: name in tdata, normalized to a bounded copy) or a release
// (tuser 1: tag in tdata); each yields exactly one output transfer with the
// tag and a status. Names and counts sit in one single-port-read memory, the
// per-tag valid bits in flip-flops that reset clears, so the table is usable
// right after reset. An acquire scans the memory one entry per cycle,
// pipelined against the registered read: a hit ends the scan early, a
// miss or a full table scans all MAX_TAGS entries. A release reads the
// entry, then updates its count or frees the tag; an ignored one skips both. Items are
// handled one at a time; the output register holds a result until it is
// taken while the next input transfer is already accepted.
module refcounted_name_tag_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rnta_pkg::S_DATA_W-1:0] i_s_tdata,  // name_key[63:0], tag_in[70:64]
    input  logic                          i_s_tuser,  // action
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rnta_pkg::M_DATA_W-1:0] o_m_tdata   // tag_out[6:0], status[9:7]
);

    import rnta_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REL_RD,
        S_REL_WR,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [NAME_W-1:0]   r_name;
    logic [IDX_W:0]      r_scan_addr;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_free_idx;
    logic [IDX_W-1:0]    r_idx;
    logic [MAX_TAGS-1:0] r_valid;
    logic [TAG_W-1:0]    r_res_tag;
    logic [STAT_W-1:0]   r_res_status;
    logic                r_m_tvalid;
    logic [TAG_W-1:0]    r_m_tag;
    logic [STAT_W-1:0]   r_m_status;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;

    logic                s_xfer;
    logic                out_free;
    logic [NAME_W-1:0]   in_key;
    logic [TAG_W-1:0]    in_tag;
    logic [TAG_W-1:0]    in_tag_m1;
    logic                rel_ok;
    logic                cur_valid;
    logic                hit;
    logic                cur_free;
    logic                last;
    logic                can_alloc;
    logic [IDX_W-1:0]    alloc_idx;
    logic                rel_free;

    rnta_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TAGS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry   = t_entry'(ram_rdata);
    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = M_DATA_W'({r_m_status, r_m_tag});

    assign in_key    = i_s_tdata[NAME_W-1:0];
    assign in_tag    = i_s_tdata[NAME_W +: TAG_W];
    assign in_tag_m1 = in_tag - TAG_W'(1);
    assign rel_ok    = (in_tag != '0) && (in_tag <= TAG_W'(MAX_TAGS))
                       && r_valid[in_tag_m1[IDX_W-1:0]];

    assign cur_valid = r_valid[r_cmp_idx];
    assign hit       = r_cmp_vld && cur_valid && (rd_entry.name == r_name);
    assign cur_free  = r_cmp_vld && !cur_valid;
    assign last      = (r_cmp_idx == IDX_W'(MAX_TAGS - 1));
    assign can_alloc = r_free_found || cur_free;
    assign alloc_idx = r_free_found ? r_free_idx : r_cmp_idx;
    assign rel_free  = (rd_entry.refs <= REFS_W'(1));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cmp_idx;
        ram_wdata = '{refs: REFS_W'(1), name: r_name};
        ram_re    = 1'b0;
        ram_raddr = r_scan_addr[IDX_W-1:0];
        case (r_state)
            S_SCAN: begin
                ram_re = (r_scan_addr < (IDX_W + 1)'(MAX_TAGS));
                if (hit) begin
                    ram_we         = 1'b1;
                    ram_wdata.refs = (rd_entry.refs == '1) ? rd_entry.refs
                                     : rd_entry.refs + REFS_W'(1);
                end else if (r_cmp_vld && last && can_alloc) begin
                    ram_we    = 1'b1;
                    ram_waddr = alloc_idx;
                end
            end
            S_REL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
            end
            S_REL_WR: begin
                ram_waddr = r_idx;
                ram_we    = !rel_free;
                ram_wdata = '{refs: rd_entry.refs - REFS_W'(1), name: rd_entry.name};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_m_tvalid <= 1'b0;
            r_cmp_vld  <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_name       <= f_normalize(in_key);
                        r_idx        <= in_tag_m1[IDX_W-1:0];
                        r_scan_addr  <= '0;
                        r_cmp_vld    <= 1'b0;
                        r_free_found <= 1'b0;
                        if (!i_s_tuser) begin
                            r_state <= S_SCAN;
                        end else if (rel_ok) begin
                            r_state <= S_REL_RD;
                        end else begin
                            r_res_tag    <= '0;
                            r_res_status <= ST_IGNORED;
                            r_state      <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    // last compare comes in the cycle after the final read, so ram_re is low then
                    r_cmp_vld <= ram_re && !hit;
                    r_cmp_idx <= ram_raddr;
                    if (ram_re) begin
                        r_scan_addr <= r_scan_addr + (IDX_W + 1)'(1);
                    end
                    if (cur_free && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_cmp_idx;
                    end
                    if (hit) begin
                        r_res_tag    <= TAG_W'(r_cmp_idx) + TAG_W'(1);
                        r_res_status <= ST_MATCHED;
                        r_state      <= S_FIN;
                    end else if (r_cmp_vld && last) begin
                        r_state <= S_FIN;
                        if (can_alloc) begin
                            r_valid[alloc_idx] <= 1'b1;
                            r_res_tag          <= TAG_W'(alloc_idx) + TAG_W'(1);
                            r_res_status       <= ST_ALLOCATED;
                        end else begin
                            r_res_tag    <= '0;
                            r_res_status <= ST_FULL;
                        end
                    end
                end
                S_REL_RD: begin
                    r_state <= S_REL_WR;
                end
                S_REL_WR: begin
                    r_res_tag <= '0;
                    if (rel_free) begin
                        r_valid[r_idx] <= 1'b0;
                        r_res_status   <= ST_FREED;
                    end else begin
                        r_res_status <= ST_HELD;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_m_tag    <= r_res_tag;
                        r_m_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RNTA_ASSERT(a_we_state, ram_we |-> (r_state == S_SCAN || r_state == S_REL_WR))
    `RNTA_ASSERT(a_full_all_valid, (r_state == S_FIN && r_res_status == ST_FULL) |-> (&r_valid))
    `RNTA_ASSERT(a_alloc_tag, (r_m_tvalid && r_m_status == ST_ALLOCATED) |-> (r_m_tag != '0))
    `RNTA_ASSERT(a_accept_busy, s_xfer |=> (r_state != S_IDLE))
    `RNTA_ASSERT_RST(a_rst_out, !i_rst_n |=> (!o_m_tvalid && r_valid == '0))

endmodule

// ----- tb/refcounted_name_tag_allocator_test.sv -----
`timescale 1ns / 1ps

module refcounted_name_tag_allocator_test;
    import rnta_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int ITEM_COUNT    = 850;
    localparam int CALM_TAIL     = 120;
    localparam int POOL_SIZE     = 96;
    localparam logic [REFS_W-1:0] REFS_TOP = '1;
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [NAME_W-1:0] key;
        logic [TAG_W-1:0]  tag;
    } t_tag_request;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [STAT_W-1:0] status;
    } t_grant;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;   // name_key[63:0], tag_in[70:64]
    logic                i_s_tuser  = 1'b0; // action
    logic                i_m_tready = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [M_DATA_W-1:0] o_m_tdata;         // tag_out[6:0], status[9:7]

    refcounted_name_tag_allocator uut (.*);

    // shadow table
    bit                live_tag  [MAX_TAGS];
    logic [NAME_W-1:0] live_name [MAX_TAGS];
    logic [REFS_W-1:0] live_refs [MAX_TAGS];

    t_tag_request      request_q[$];
    t_grant            expected_grant_q[$];
    logic [NAME_W-1:0] name_pool[POOL_SIZE];

    int src_gap      = 0;
    int snk_gap      = 0;
    bit idle_on      = 1'b1;
    int errors       = 0;
    int cycles       = 0;
    int queued_items = 0;
    int status_seen[8];

    always #1 i_clk = ~i_clk;

    function automatic logic [NAME_W-1:0] bounded_name(logic [NAME_W-1:0] key);
        logic [NAME_W-1:0] kept;
        int                n;
        kept = '0;
        n    = 0;
        while (n < NAME_BYTES - 1 && key[8*n +: 8] != 8'h00) begin
            kept[8*n +: 8] = key[8*n +: 8];
            n++;
        end
        return kept;
    endfunction

    function automatic t_grant predict_grant(logic op, logic [NAME_W-1:0] key,
                                             logic [TAG_W-1:0] tag);
        t_grant            g;
        logic [NAME_W-1:0] nm;
        int                idx;
        int                slot;
        g.tag    = '0;
        g.status = ST_IGNORED;
        slot     = -1;
        if (op == OP_ACQUIRE) begin
            nm = bounded_name(key);
            for (idx = 0; idx < MAX_TAGS; idx++) begin
                if (slot < 0 && live_tag[idx] && live_name[idx] == nm) slot = idx;
            end
            if (slot >= 0) begin
                if (live_refs[slot] != REFS_TOP) live_refs[slot] = live_refs[slot] + 1'b1;
                g.tag    = TAG_W'(slot + 1);
                g.status = ST_MATCHED;
            end else begin
                for (idx = 0; idx < MAX_TAGS; idx++) begin
                    if (slot < 0 && !live_tag[idx]) slot = idx;
                end
                if (slot >= 0) begin
                    live_tag[slot]  = 1'b1;
                    live_name[slot] = nm;
                    live_refs[slot] = REFS_W'(1);
                    g.tag           = TAG_W'(slot + 1);
                    g.status        = ST_ALLOCATED;
                end else begin
                    g.status = ST_FULL;
                end
            end
        end else if (tag >= 1 && tag <= MAX_TAGS) begin
            slot = int'(tag) - 1;
            if (live_tag[slot]) begin
                if (live_refs[slot] <= 1) begin
                    live_refs[slot] = '0;
                    live_tag[slot]  = 1'b0;
                    g.status        = ST_FREED;
                end else begin
                    live_refs[slot] = live_refs[slot] - 1'b1;
                    g.status        = ST_HELD;
                end
            end
        end
        return g;
    endfunction

    task automatic queue_acquire(logic [NAME_W-1:0] key);
        t_tag_request rq;
        rq.op  = OP_ACQUIRE;
        rq.key = key;
        rq.tag = TAG_W'($urandom);
        request_q.push_back(rq);
        queued_items++;
    endtask

    task automatic queue_release(logic [TAG_W-1:0] tag);
        t_tag_request rq;
        rq.op  = OP_RELEASE;
        rq.key = {$urandom, $urandom};
        rq.tag = tag;
        request_q.push_back(rq);
        queued_items++;
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || i_s_tvalid || expected_grant_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // driver: a request is predicted at the edge where its transfer happens
    always @(posedge i_clk) begin : drive
        t_tag_request req;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_grant_q.push_back(predict_grant(i_s_tuser, i_s_tdata[NAME_W-1:0],
                                                         i_s_tdata[NAME_W +: TAG_W]));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap    <= src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    req = request_q.pop_front();
                    i_s_tdata  <= S_DATA_W'({req.tag, req.key});
                    i_s_tuser  <= req.op;
                    i_s_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 14);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch
        t_grant            want;
        logic [TAG_W-1:0]  got_tag;
        logic [STAT_W-1:0] got_status;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got_tag    = o_m_tdata[TAG_W-1:0];
                got_status = o_m_tdata[TAG_W +: STAT_W];
                if (got_status <= ST_IGNORED) status_seen[got_status]++;
                if (expected_grant_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected transfer: tag %0d status %0d", got_tag, got_status);
                    end
                end else begin
                    want = expected_grant_q.pop_front();
                    if (got_tag !== want.tag || got_status !== want.status) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected tag %0d status %0d, got tag %0d status %0d",
                                     want.tag, want.status, got_tag, got_status);
                        end
                    end
                end
            end
            if (snk_gap != 0) begin
                snk_gap    <= snk_gap - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) snk_gap <= $urandom_range(1, 14);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int                n;
        int                mode;
        int                acq_pct;
        int                batch_len;
        int                live_list[$];

        for (n = 0; n < POOL_SIZE; n++) begin
            name_pool[n] = {$urandom, $urandom};
            case (n % 8)
                1: name_pool[n] = {8'($urandom), name_pool[n-1][55:0]};
                2: name_pool[n][8*$urandom_range(0, 6) +: 8] = 8'h00;
                3: name_pool[n] = name_pool[n] & 64'h0000_0000_0000_FFFF;
                default: begin
                end
            endcase
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // releases on an empty table, out of range tags
        queue_release(7'd0);
        queue_release(7'd1);
        queue_release(7'd127);
        queue_release(7'd65);
        // zero name, truncated names, names cut at a zero byte
        queue_acquire(64'h0000_0000_0000_0000);
        queue_acquire(64'h0000_0000_0000_0000);
        queue_acquire(64'hFFFF_FFFF_FFFF_FFFF);
        queue_acquire(64'hAAFF_FFFF_FFFF_FFFF);
        queue_acquire(64'h1122_3344_0055_6677);
        queue_acquire(64'h0000_0000_0055_6677);
        queue_acquire(64'h8000_0000_0000_0000);
        queue_release(7'd2);
        queue_release(7'd2);
        queue_release(7'd2);
        queue_acquire(64'h0102_0304_0506_0708);
        queue_release(7'd1);
        queue_release(7'd1);
        queue_release(7'd1);
        queue_release(7'd64);
        queue_release(7'd2);
        queue_release(7'd3);
        wait_drained();

        while (queued_items < ITEM_COUNT) begin
            if (queued_items > ITEM_COUNT - CALM_TAIL) idle_on = 1'b0;
            live_list.delete();
            for (n = 0; n < MAX_TAGS; n++) begin
                if (live_tag[n]) live_list.push_back(n + 1);
            end
            mode = $urandom_range(0, 3);
            if (mode == 3) begin
                // sweep the whole pool: fills the table
                for (n = 0; n < POOL_SIZE; n++) queue_acquire(name_pool[n]);
            end else begin
                acq_pct   = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
                batch_len = $urandom_range(8, 30);
                repeat (batch_len) begin
                    if ($urandom_range(0, 99) < acq_pct) begin
                        if ($urandom_range(0, 9) == 0) begin
                            queue_acquire({$urandom, $urandom});
                        end else begin
                            queue_acquire(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
                        end
                    end else if (live_list.size() != 0 && $urandom_range(0, 6) != 0) begin
                        queue_release(TAG_W'(live_list[$urandom_range(0, live_list.size() - 1)]));
                    end else begin
                        queue_release(TAG_W'($urandom_range(0, 127)));
                    end
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("%0d requests: %0d matched, %0d allocated, %0d full, %0d held, %0d freed",
                 queued_items, status_seen[ST_MATCHED], status_seen[ST_ALLOCATED],
                 status_seen[ST_FULL], status_seen[ST_HELD], status_seen[ST_FREED]);
        $display("%0d ignored releases, table filled by pool sweeps, %0d mismatches",
                 status_seen[ST_IGNORED], errors);
        if (errors == 0 && expected_grant_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
